>>> rtl/xmha_pkg.sv
// Shared types and constants for the extended memory handle allocator.
// Used by the cell, the cell chain, the controller and the top level.
package xmha_pkg;

    // Handle table geometry.
    localparam int SLOTS = 32;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int KB_W  = 16;
    localparam int POS_W = KB_W + 1;

    // Function codes.
    localparam logic [7:0] OP_VERSION     = 8'd0;
    localparam logic [7:0] OP_HMA_CLAIM   = 8'd1;
    localparam logic [7:0] OP_HMA_RELEASE = 8'd2;
    localparam logic [7:0] OP_A20_ON_G    = 8'd3;
    localparam logic [7:0] OP_A20_OFF_G   = 8'd4;
    localparam logic [7:0] OP_A20_ON_L    = 8'd5;
    localparam logic [7:0] OP_A20_OFF_L   = 8'd6;
    localparam logic [7:0] OP_A20_QUERY   = 8'd7;
    localparam logic [7:0] OP_FREE_QUERY  = 8'd8;
    localparam logic [7:0] OP_ALLOC       = 8'd9;
    localparam logic [7:0] OP_FREE        = 8'd10;
    localparam logic [7:0] OP_INFO        = 8'd14;
    localparam logic [7:0] OP_REALLOC     = 8'd15;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_ABSENT    = 3'd1;
    localparam logic [2:0] ERR_HMA       = 3'd2;
    localparam logic [2:0] ERR_NOMEM     = 3'd3;
    localparam logic [2:0] ERR_NOHANDLE  = 3'd4;
    localparam logic [2:0] ERR_BADHANDLE = 3'd5;

    localparam logic [15:0] VERSION_WORD = 16'h0200;
    localparam logic [15:0] POOL_RESET   = 16'd4096;

    // Configuration register index.
    localparam logic REG_POOL = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Token that travels down the cell chain during one sweep.
    typedef struct packed {
        logic             vld;
        logic             found;
        logic [KB_W-1:0]  best_off;
        logic [IDX_W-1:0] best_idx;
        logic [KB_W-1:0]  best_size;
        logic [CNT_W-1:0] nfree;
        logic             ffree_found;
        logic [IDX_W-1:0] ffree_idx;
        logic             h_used;
        logic [KB_W-1:0]  h_off;
        logic [KB_W-1:0]  h_size;
    } t_tok;

    // Search window and target slot, held steady during a sweep.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [IDX_W-1:0] tgt;
    } t_ctl;

    // Table update command broadcast to every cell.
    typedef struct packed {
        logic             clr_seen;
        logic             mark;
        logic [IDX_W-1:0] mark_idx;
        logic             wr_used_en;
        logic             wr_off_en;
        logic             wr_size_en;
        logic [IDX_W-1:0] wr_idx;
        logic             wr_used;
        logic [KB_W-1:0]  wr_off;
        logic [KB_W-1:0]  wr_size;
    } t_cmd;

endpackage

>>> rtl/extended_memory_handle_allocator.sv
// Top level of the extended memory handle allocator: stream ports, APB
// register and the chain of slot cells. Depends on xmha_pkg, xmha_chain, xmha_ctrl.

// One request is taken at a time. Version, HMA and A20 functions answer without
// a sweep. Every other function runs sweeps down the row of 32 slot cells, each
// sweep ending with an evaluation: free, info and shrinking take one sweep,
// growing takes two, and allocation and the free query take one sweep per block
// walked in address order plus one. The result sits in an output register, and
// the next request may enter while it waits there. The pool size register resets
// to 4096 KB; zero makes every request fail with code 1.
module extended_memory_handle_allocator import xmha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] operation, [23:8] handle_number, [39:24] request_size_kb
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] succeeded, [3:1] error_code, [19:4] primary_value,
    // [35:20] secondary_value, [51:36] third_value, [55:52] zero
    output logic [55:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_pool;
    t_ctl        ctl;
    t_cmd        cmd;
    t_tok        tok_in;
    t_tok        tok_out;

    // Pool size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= POOL_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_POOL) begin
            r_pool <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POOL) ? {16'd0, r_pool} : 32'd0;

    xmha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_vld  (i_s_axis_tvalid),
        .o_req_rdy  (o_s_axis_tready),
        .i_op       (i_s_axis_tdata[7:0]),
        .i_handle   (i_s_axis_tdata[23:8]),
        .i_size     (i_s_axis_tdata[39:24]),
        .i_pool     (r_pool),
        .o_res_vld  (o_m_axis_tvalid),
        .i_res_rdy  (i_m_axis_tready),
        .o_res_data (o_m_axis_tdata),
        .o_ctl      (ctl),
        .o_cmd      (cmd),
        .o_tok      (tok_in),
        .i_tok      (tok_out)
    );

    xmha_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_cmd   (cmd),
        .i_tok   (tok_in),
        .o_tok   (tok_out)
    );

endmodule

>>> rtl/xmha_cell.sv
// One handle slot: used flag, offset, size and walk mark, plus one token stage.
// Depends on xmha_pkg.
module xmha_cell import xmha_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_ctl             i_ctl,
    input  t_cmd             i_cmd,
    input  t_tok             i_tok,
    output t_tok             o_tok
);

    logic            r_used;
    logic            r_seen;
    logic [KB_W-1:0] r_off;
    logic [KB_W-1:0] r_size;
    t_tok            r_tok;
    t_tok            n_tok;
    logic            mark_me;
    logic            wr_me;
    logic            take;

    assign mark_me = i_cmd.mark && (i_cmd.mark_idx == i_idx);
    assign wr_me   = (i_cmd.wr_idx == i_idx);

    // Slot state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_seen <= 1'b0;
            r_off  <= '0;
            r_size <= '0;
        end else begin
            if (i_cmd.clr_seen) begin
                r_seen <= mark_me;
            end else if (mark_me) begin
                r_seen <= 1'b1;
            end
            if (wr_me && i_cmd.wr_used_en) begin
                r_used <= i_cmd.wr_used;
            end
            if (wr_me && i_cmd.wr_off_en) begin
                r_off <= i_cmd.wr_off;
            end
            if (wr_me && i_cmd.wr_size_en) begin
                r_size <= i_cmd.wr_size;
            end
        end
    end

    // A strictly lower offset replaces the candidate, so ties keep the lower slot.
    assign take = r_used && !r_seen && ({1'b0, r_off} >= i_ctl.pos)
                  && (r_off < i_tok.best_off);

    always_comb begin
        n_tok = i_tok;
        if (take) begin
            n_tok.found     = 1'b1;
            n_tok.best_off  = r_off;
            n_tok.best_idx  = i_idx;
            n_tok.best_size = r_size;
        end
        if (!r_used) begin
            n_tok.nfree = i_tok.nfree + CNT_W'(1);
            if (!i_tok.ffree_found) begin
                n_tok.ffree_found = 1'b1;
                n_tok.ffree_idx   = i_idx;
            end
        end
        if (i_ctl.tgt == i_idx) begin
            n_tok.h_used = r_used;
            n_tok.h_off  = r_off;
            n_tok.h_size = r_size;
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.found       <= n_tok.found;
        r_tok.best_off    <= n_tok.best_off;
        r_tok.best_idx    <= n_tok.best_idx;
        r_tok.best_size   <= n_tok.best_size;
        r_tok.nfree       <= n_tok.nfree;
        r_tok.ffree_found <= n_tok.ffree_found;
        r_tok.ffree_idx   <= n_tok.ffree_idx;
        r_tok.h_used      <= n_tok.h_used;
        r_tok.h_off       <= n_tok.h_off;
        r_tok.h_size      <= n_tok.h_size;
    end

    assign o_tok = r_tok;

endmodule

>>> rtl/xmha_chain.sv
// Row of handle slot cells; a token enters at slot 0 and leaves after the last.
// Depends on xmha_pkg and xmha_cell.
module xmha_chain import xmha_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ctl i_ctl,
    input  t_cmd i_cmd,
    input  t_tok i_tok,
    output t_tok o_tok
);

    t_tok link [SLOTS+1];

    assign link[0] = i_tok;

    // One cell per slot, each feeding its neighbor.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        xmha_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (i_ctl),
            .i_cmd   (i_cmd),
            .i_tok   (link[g]),
            .o_tok   (link[g+1])
        );
    end

    assign o_tok = link[SLOTS];

endmodule

>>> rtl/xmha_ctrl.sv
// Request sequencer: decodes functions, runs sweeps over the cell chain and
// builds the result. Depends on xmha_pkg.
module xmha_ctrl import xmha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_vld,
    output logic        o_req_rdy,
    input  logic [7:0]  i_op,
    input  logic [15:0] i_handle,
    input  logic [15:0] i_size,
    input  logic [15:0] i_pool,
    output logic        o_res_vld,
    input  logic        i_res_rdy,
    output logic [55:0] o_res_data,
    output t_ctl        o_ctl,
    output t_cmd        o_cmd,
    output t_tok        o_tok,
    input  t_tok        i_tok
);

    t_state           r_state, n_state;
    logic [7:0]       r_op, n_op;
    logic [15:0]      r_handle, n_handle;
    logic [15:0]      r_size, n_size;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_big, n_big;
    logic [POS_W-1:0] r_sum, n_sum;
    logic [KB_W-1:0]  r_hoff, n_hoff;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic             r_first, n_first;
    logic             r_launch, n_launch;
    logic             r_hma, n_hma;
    logic             r_a20, n_a20;
    logic [2:0]       r_err, n_err;
    logic [15:0]      r_pv, n_pv;
    logic [15:0]      r_sv, n_sv;
    logic [15:0]      r_tv, n_tv;
    logic             r_mvalid;
    logic [55:0]      r_mdata;

    logic             accept;
    logic [POS_W-1:0] pool17;
    logic [POS_W-1:0] off17;
    logic [POS_W-1:0] endb;
    logic [POS_W-1:0] endh;
    logic [POS_W-1:0] gap;
    logic [POS_W:0]   need;
    logic [POS_W-1:0] room;
    logic [POS_W-1:0] lim;
    logic             h_ok;
    logic [IDX_W-1:0] slot_sel;
    logic             out_free;

    assign o_req_rdy = (r_state == ST_IDLE);
    assign accept    = i_req_vld && o_req_rdy;
    assign out_free  = !r_mvalid || i_res_rdy;

    assign pool17   = {1'b0, i_pool};
    assign off17    = {1'b0, i_tok.best_off};
    assign endb     = off17 + {1'b0, i_tok.best_size};
    assign endh     = {1'b0, i_tok.h_off} + {1'b0, i_tok.h_size};
    assign need     = {1'b0, r_pos} + {2'b00, r_size};
    assign room     = pool17 - r_pos;
    assign lim      = i_tok.found ? off17 : pool17;
    assign h_ok     = (r_handle != 16'd0) && (r_handle <= 16'(SLOTS)) && i_tok.h_used;
    assign slot_sel = r_first ? i_tok.ffree_idx : r_slot;

    // Gap before the block found by this sweep, or up to the pool end.
    always_comb begin
        if (i_tok.found) begin
            gap = (off17 > r_pos) ? (off17 - r_pos) : '0;
        end else begin
            gap = room;
        end
    end

    assign o_ctl.pos = r_pos;
    assign o_ctl.tgt = IDX_W'(r_handle - 16'd1);

    // Fresh token: no candidate yet, the pool end bounds the search.
    always_comb begin
        o_tok             = '0;
        o_tok.vld         = r_launch;
        o_tok.best_off    = i_pool;
    end

    // Next state, table commands and result.
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_handle = r_handle;
        n_size   = r_size;
        n_pos    = r_pos;
        n_big    = r_big;
        n_sum    = r_sum;
        n_hoff   = r_hoff;
        n_slot   = r_slot;
        n_first  = r_first;
        n_launch = 1'b0;
        n_hma    = r_hma;
        n_a20    = r_a20;
        n_err    = r_err;
        n_pv     = r_pv;
        n_sv     = r_sv;
        n_tv     = r_tv;
        o_cmd    = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op     = i_op;
                    n_handle = i_handle;
                    n_size   = i_size;
                    n_err    = ERR_NONE;
                    n_pv     = '0;
                    n_sv     = '0;
                    n_tv     = '0;
                    n_state  = ST_DONE;
                    if (i_pool == 16'd0) begin
                        n_err = ERR_ABSENT;
                    end else begin
                        case (i_op)
                            OP_VERSION: begin
                                n_pv = VERSION_WORD;
                                n_tv = VERSION_WORD;
                            end
                            OP_HMA_CLAIM: begin
                                if (r_hma) begin
                                    n_err = ERR_HMA;
                                end else begin
                                    n_hma = 1'b1;
                                    n_a20 = 1'b1;
                                    n_pv  = 16'd1;
                                end
                            end
                            OP_HMA_RELEASE: begin
                                n_hma = 1'b0;
                                n_pv  = 16'd1;
                            end
                            OP_A20_ON_G, OP_A20_ON_L: begin
                                n_a20 = 1'b1;
                                n_pv  = 16'd1;
                            end
                            OP_A20_OFF_G, OP_A20_OFF_L: begin
                                n_a20 = 1'b0;
                                n_pv  = 16'd1;
                            end
                            OP_A20_QUERY: begin
                                n_pv = {15'd0, r_a20};
                            end
                            OP_FREE_QUERY, OP_ALLOC, OP_FREE, OP_INFO, OP_REALLOC: begin
                                o_cmd.clr_seen = 1'b1;
                                n_pos    = '0;
                                n_big    = '0;
                                n_sum    = '0;
                                n_first  = 1'b1;
                                n_launch = 1'b1;
                                n_state  = ST_SWEEP;
                            end
                            default: begin
                                n_err = ERR_ABSENT;
                            end
                        endcase
                    end
                end
            end
            ST_SWEEP: begin
                if (i_tok.vld) begin
                    n_first = 1'b0;
                    case (r_op)
                        OP_FREE_QUERY: begin
                            // Walk blocks in address order, summing the gaps and keeping the largest.
                            n_sum = r_sum + gap;
                            n_big = (gap > r_big) ? gap : r_big;
                            if (!i_tok.found || endb >= pool17) begin
                                n_pv    = n_big[15:0];
                                n_sv    = n_sum[15:0];
                                n_state = ST_DONE;
                            end else begin
                                n_pos      = endb;
                                o_cmd.mark = 1'b1;
                                o_cmd.mark_idx = i_tok.best_idx;
                                n_launch   = 1'b1;
                            end
                        end
                        OP_ALLOC: begin
                            if (r_first) begin
                                n_slot = i_tok.ffree_idx;
                            end
                            if (r_first && i_tok.nfree == '0) begin
                                n_err   = ERR_NOHANDLE;
                                n_state = ST_DONE;
                            end else if (r_first && (r_size == 16'd0 || r_size > i_pool)) begin
                                n_err   = ERR_NOMEM;
                                n_state = ST_DONE;
                            end else if (i_tok.found ? ({1'b0, off17} >= need)
                                                     : (room >= {1'b0, r_size})) begin
                                // First fit: the request lands at the current position.
                                o_cmd.wr_idx     = slot_sel;
                                o_cmd.wr_used_en = 1'b1;
                                o_cmd.wr_off_en  = 1'b1;
                                o_cmd.wr_size_en = 1'b1;
                                o_cmd.wr_used    = 1'b1;
                                o_cmd.wr_off     = r_pos[KB_W-1:0];
                                o_cmd.wr_size    = r_size;
                                n_pv    = 16'd1;
                                n_sv    = 16'(slot_sel) + 16'd1;
                                n_state = ST_DONE;
                            end else if (!i_tok.found || endb > pool17) begin
                                n_err   = ERR_NOMEM;
                                n_state = ST_DONE;
                            end else begin
                                n_pos      = endb;
                                o_cmd.mark = 1'b1;
                                o_cmd.mark_idx = i_tok.best_idx;
                                n_launch   = 1'b1;
                            end
                        end
                        OP_FREE: begin
                            n_state = ST_DONE;
                            if (!h_ok) begin
                                n_err = ERR_BADHANDLE;
                            end else begin
                                o_cmd.wr_idx     = o_ctl.tgt;
                                o_cmd.wr_used_en = 1'b1;
                                o_cmd.wr_used    = 1'b0;
                                n_pv = 16'd1;
                            end
                        end
                        OP_INFO: begin
                            n_state = ST_DONE;
                            if (!h_ok) begin
                                n_err = ERR_BADHANDLE;
                            end else begin
                                n_pv = 16'd1;
                                n_sv = i_tok.h_size;
                                n_tv = 16'(i_tok.nfree);
                            end
                        end
                        OP_REALLOC: begin
                            if (r_first) begin
                                if (!h_ok) begin
                                    n_err   = ERR_BADHANDLE;
                                    n_state = ST_DONE;
                                end else if (r_size <= i_tok.h_size) begin
                                    o_cmd.wr_idx     = o_ctl.tgt;
                                    o_cmd.wr_size_en = 1'b1;
                                    o_cmd.wr_size    = r_size;
                                    n_pv    = 16'd1;
                                    n_state = ST_DONE;
                                end else begin
                                    // Second sweep finds the next block past this one.
                                    n_hoff         = i_tok.h_off;
                                    n_pos          = endh;
                                    o_cmd.clr_seen = 1'b1;
                                    o_cmd.mark     = 1'b1;
                                    o_cmd.mark_idx = o_ctl.tgt;
                                    n_launch       = 1'b1;
                                end
                            end else begin
                                n_state = ST_DONE;
                                if (({1'b0, r_hoff} + {1'b0, r_size}) > lim) begin
                                    n_err = ERR_NOMEM;
                                end else begin
                                    o_cmd.wr_idx     = o_ctl.tgt;
                                    o_cmd.wr_size_en = 1'b1;
                                    o_cmd.wr_size    = r_size;
                                    n_pv = 16'd1;
                                end
                            end
                        end
                        default: begin
                            n_err   = ERR_ABSENT;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
            r_first  <= 1'b0;
            r_hma    <= 1'b0;
            r_a20    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_first  <= n_first;
            r_hma    <= n_hma;
            r_a20    <= n_a20;
        end
    end

    // Request fields and walk state.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_handle <= n_handle;
        r_size   <= n_size;
        r_pos    <= n_pos;
        r_big    <= n_big;
        r_sum    <= n_sum;
        r_hoff   <= n_hoff;
        r_slot   <= n_slot;
        r_err    <= n_err;
        r_pv     <= n_pv;
        r_sv     <= n_sv;
        r_tv     <= n_tv;
    end

    // Output register; errors clear every value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_mvalid <= 1'b1;
        end else if (i_res_rdy) begin
            r_mvalid <= 1'b0;
        end
        if (r_state == ST_DONE && out_free) begin
            if (r_err == ERR_NONE) begin
                r_mdata <= {4'd0, r_tv, r_sv, r_pv, ERR_NONE, 1'b1};
            end else begin
                r_mdata <= {4'd0, 48'd0, r_err, 1'b0};
            end
        end
    end

    assign o_res_vld  = r_mvalid;
    assign o_res_data = r_mdata;

    // A launched token leaves the last cell exactly one row later.
    a_sweep_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch |-> ##(SLOTS) i_tok.vld)
        else $error("sweep token did not arrive after one pass");

    // Tokens only arrive while a sweep is waited on.
    a_tok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok.vld |-> (r_state == ST_SWEEP))
        else $error("token arrived outside a sweep");

    // No table write while a token is in flight.
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && !i_tok.vld) |-> !(o_cmd.wr_used_en || o_cmd.wr_size_en))
        else $error("table written during a sweep");

    // An accepted request always leaves the idle state.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("request accepted without starting");

endmodule
